@@ design/ms_pkg.sv @@
// ms_pkg: shared types and constants for the merge sorter
// holds the data width and the sequencer state type
// no dependencies
package ms_pkg;

	// width of one sorted element
	localparam int DATA_W = 32;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BLK,
		ST_RD,
		ST_CMP,
		ST_OUT_RD,
		ST_OUT_CAP
	} state_t;

endpackage

@@ design/merge_sorter.sv @@
// merge_sorter: stable ascending sort of up to DEPTH signed elements per set.
// loading writes each transfer that fits into memory 0; the set ends with an item marked last.
// sorting runs ceil(log2 n) bottom-up merge passes between two memories;
// each run pair is set up, then each element is read, then compared and written.
// each result is read, then captured; a held result waits until the sink is ready.
// reset clears the sequencer, the element count and output valid; memories keep contents.
module merge_sorter #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid,
	output logic                             ready,
	input  logic signed [ms_pkg::DATA_W-1:0] value,
	input  logic                             last,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic signed [ms_pkg::DATA_W-1:0] value_res,
	output logic                             final_item,
	output logic                             truncated
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = CW + 2;

	ms_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [CW-1:0] k_q;
	logic          ovf_q;
	logic          sel_q;
	logic          res_valid_q;
	logic [XW-1:0] lo_q, w_q, mid_q, hi_q, l_q, r_q, i_q;

	logic [CW-1:0] count_next;
	logic          has_room;
	logic [XW-1:0] n_x;
	logic [XW-1:0] lo_w, lo_2w, w_2, blk_mid, blk_hi;
	logic          blk_end, take_r, out_final;

	logic          m0_we, m1_we;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	logic signed [ms_pkg::DATA_W-1:0] wdata, merged;
	logic signed [ms_pkg::DATA_W-1:0] m0_a, m0_b, m1_a, m1_b, src_a, src_b;

	// element memories, ping-pong between passes
	ms_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram0 (
		.clk(clk), .we(m0_we), .waddr(waddr), .wdata(wdata),
		.raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(m0_a), .rdata_b(m0_b)
	);

	ms_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram1 (
		.clk(clk), .we(m1_we), .waddr(waddr), .wdata(wdata),
		.raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(m1_a), .rdata_b(m1_b)
	);

	// run bounds and merge decision
	always_comb begin
		has_room   = count_q < CW'(DEPTH);
		count_next = count_q + CW'(has_room);
		n_x        = XW'(count_q);
		lo_w       = lo_q + w_q;
		lo_2w      = lo_q + (w_q << 1);
		w_2        = w_q << 1;
		blk_mid    = (lo_w < n_x) ? lo_w : n_x;
		blk_hi     = (lo_2w < n_x) ? lo_2w : n_x;
		blk_end    = (i_q + XW'(1)) == hi_q;
		src_a      = sel_q ? m1_a : m0_a;
		src_b      = sel_q ? m1_b : m0_b;
		take_r     = (l_q >= mid_q) || ((r_q < hi_q) && (src_b < src_a));
		merged     = take_r ? src_b : src_a;
		out_final  = (k_q + CW'(1)) == count_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ms_pkg::ST_LOAD: begin
				if (valid && last) begin
					state_d = (count_next > CW'(1)) ? ms_pkg::ST_BLK : ms_pkg::ST_OUT_RD;
				end
			end
			ms_pkg::ST_BLK: state_d = ms_pkg::ST_RD;
			ms_pkg::ST_RD:  state_d = ms_pkg::ST_CMP;
			ms_pkg::ST_CMP: begin
				if (!blk_end) begin
					state_d = ms_pkg::ST_RD;
				end else if (lo_2w < n_x || w_2 < n_x) begin
					state_d = ms_pkg::ST_BLK;
				end else begin
					state_d = ms_pkg::ST_OUT_RD;
				end
			end
			ms_pkg::ST_OUT_RD: begin
				if (!res_valid_q || res_ready) begin
					state_d = ms_pkg::ST_OUT_CAP;
				end
			end
			ms_pkg::ST_OUT_CAP: begin
				state_d = out_final ? ms_pkg::ST_LOAD : ms_pkg::ST_OUT_RD;
			end
			default: state_d = ms_pkg::ST_LOAD;
		endcase
	end

	// memory port control and handshake outputs
	always_comb begin
		ready   = 1'b0;
		m0_we   = 1'b0;
		m1_we   = 1'b0;
		waddr   = i_q[AW-1:0];
		wdata   = merged;
		raddr_a = l_q[AW-1:0];
		raddr_b = r_q[AW-1:0];
		unique case (state_q)
			ms_pkg::ST_LOAD: begin
				ready = 1'b1;
				m0_we = valid && has_room;
				waddr = count_q[AW-1:0];
				wdata = value;
			end
			ms_pkg::ST_CMP: begin
				m0_we = sel_q;
				m1_we = !sel_q;
			end
			ms_pkg::ST_OUT_RD: begin
				raddr_a = k_q[AW-1:0];
			end
			default: begin
				ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ms_pkg::ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			sel_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ms_pkg::ST_LOAD && valid) begin
				count_q <= count_next;
				if (!has_room) begin
					ovf_q <= 1'b1;
				end
				if (last) begin
					sel_q <= 1'b0;
				end
			end
			if (state_q == ms_pkg::ST_CMP && blk_end && !(lo_2w < n_x)) begin
				sel_q <= !sel_q;
			end
			if (state_q == ms_pkg::ST_OUT_CAP) begin
				res_valid_q <= 1'b1;
				if (out_final) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// run pointers and result register
	always_ff @(posedge clk) begin
		unique case (state_q)
			ms_pkg::ST_LOAD: begin
				if (valid && last) begin
					lo_q <= '0;
					w_q  <= XW'(1);
					k_q  <= '0;
				end
			end
			ms_pkg::ST_BLK: begin
				mid_q <= blk_mid;
				hi_q  <= blk_hi;
				l_q   <= lo_q;
				r_q   <= blk_mid;
				i_q   <= lo_q;
			end
			ms_pkg::ST_CMP: begin
				i_q <= i_q + XW'(1);
				if (take_r) begin
					r_q <= r_q + XW'(1);
				end else begin
					l_q <= l_q + XW'(1);
				end
				if (blk_end) begin
					if (lo_2w < n_x) begin
						lo_q <= lo_2w;
					end else begin
						lo_q <= '0;
						w_q  <= w_2;
					end
				end
			end
			ms_pkg::ST_OUT_CAP: begin
				value_res  <= src_a;
				final_item <= out_final;
				truncated  <= ovf_q;
				k_q        <= k_q + CW'(1);
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

@@ design/ms_ram.sv @@
// ms_ram: element memory with one write port and two read ports
// read data is registered
// depends on ms_pkg for the data width
module ms_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [AW-1:0]                   waddr,
	input  logic signed [ms_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]                   raddr_a,
	input  logic [AW-1:0]                   raddr_b,
	output logic signed [ms_pkg::DATA_W-1:0] rdata_a,
	output logic signed [ms_pkg::DATA_W-1:0] rdata_b
);

	logic signed [ms_pkg::DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ design/ms_checker.sv @@
// ms_checker: port-level checks on the merge sorter
// depends on ms_pkg; bound to merge_sorter at the end of this file
module ms_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             valid,
	input logic                             ready,
	input logic                             last,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic signed [ms_pkg::DATA_W-1:0] value_res,
	input logic                             final_item,
	input logic                             truncated
);

	// a stalled result keeps its contents
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(value_res)
			&& $stable(final_item) && $stable(truncated))
		else $error("stalled result changed");

	// a set end stops further loading while sorting starts
	a_set_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && last |=> !ready)
		else $error("input taken right after set end");

	// no loading between results of one set
	a_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !final_item |=> !ready)
		else $error("input taken during result output");

endmodule

bind merge_sorter ms_checker u_ms_checker (.*);

@@ test/merge_sorter_tb.sv @@
// merge_sorter_tb: self-checking testbench for the merge sorter
// feeds sets of signed values, rebuilds each sorted set and checks every result
// depends on ms_pkg and merge_sorter
module merge_sorter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_W = ms_pkg::DATA_W;

	localparam int STORE_DEPTH = 64;
	localparam int RANDOM_ITEMS = 480;
	localparam int CALM_TAIL = 80;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT = 200000;

	// value mixes for one set
	typedef enum int {
		MIX_WIDE,
		MIX_DUPS,
		MIX_EDGE,
		MIX_RISING,
		MIX_FALLING
	} val_mix_t;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		bit                       hold;
	} feed_t;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     final_item;
		logic                     truncated;
	} sorted_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     valid = 1'b0;
	logic                     ready;
	logic signed [DATA_W-1:0] value = '0;
	logic                     last = 1'b0;
	logic                     res_valid;
	logic                     res_ready = 1'b0;
	logic signed [DATA_W-1:0] value_res;
	logic                     final_item;
	logic                     truncated;

	feed_t                    pending[$];
	sorted_t                  sorted_due[$];
	logic signed [DATA_W-1:0] set_values[$];
	bit                       set_dropped;
	feed_t                    feed_next;
	sorted_t                  due_head;
	int                       gap_left;
	int                       stall_left;
	int                       errors;
	int                       items_queued;
	int                       cycle_count;

	merge_sorter #(
		.DEPTH(STORE_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.ready     (ready),
		.value     (value),
		.last      (last),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.value_res (value_res),
		.final_item(final_item),
		.truncated (truncated)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// store one transfer; on the end of a set sort it and queue the results
	task automatic absorb_element(input logic signed [DATA_W-1:0] v, input logic l);
		logic signed [DATA_W-1:0] key;
		sorted_t                  r;
		int                       j;
		if (set_values.size() < STORE_DEPTH)
			set_values.push_back(v);
		else
			set_dropped = 1'b1;
		if (l) begin
			// stable insertion sort, ascending
			for (int i = 1; i < set_values.size(); i++) begin
				key = set_values[i];
				j = i - 1;
				while (j >= 0 && set_values[j] > key) begin
					set_values[j + 1] = set_values[j];
					j--;
				end
				set_values[j + 1] = key;
			end
			foreach (set_values[k]) begin
				r.value = set_values[k];
				r.final_item = (k == set_values.size() - 1);
				r.truncated = set_dropped;
				sorted_due.push_back(r);
			end
			set_values.delete();
			set_dropped = 1'b0;
		end
	endtask

	task automatic queue_item(input logic signed [DATA_W-1:0] v, input logic l,
			input bit hold);
		feed_t f;
		f.value = v;
		f.last = l;
		f.hold = hold;
		pending.push_back(f);
		items_queued++;
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value(input val_mix_t mix,
			input int k, input int n);
		logic signed [DATA_W-1:0] v;
		case (mix)
			MIX_WIDE: begin
				v = $urandom;
			end
			MIX_DUPS: begin
				v = $signed($urandom_range(0, 6)) - 3;
			end
			MIX_EDGE: begin
				case ($urandom_range(0, 6))
					0: v = 32'sh8000_0000;
					1: v = 32'sh8000_0001;
					2: v = -1;
					3: v = 0;
					4: v = 1;
					5: v = 32'sh7FFF_FFFE;
					default: v = 32'sh7FFF_FFFF;
				endcase
			end
			MIX_RISING: begin
				v = k * 3 - 50;
			end
			default: begin
				v = (n - k) * 7 - 100;
			end
		endcase
		return v;
	endfunction

	task automatic queue_set(input int n, input val_mix_t mix, input bit hold);
		for (int k = 0; k < n; k++)
			queue_item(pick_value(mix, k, n), k == n - 1, hold && k == 0);
	endtask

	// sender: presents pending items, with random gaps and a drain hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
			value <= '0;
			last <= 1'b0;
			gap_left = 0;
		end else begin
			if (valid && ready)
				absorb_element(value, last);
			if (!valid || ready) begin
				if (gap_left > 0) begin
					gap_left--;
					valid <= 1'b0;
				end else if (pending.size() == 0 ||
						(pending[0].hold && sorted_due.size() != 0)) begin
					valid <= 1'b0;
				end else if (pending.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 5);
					valid <= 1'b0;
				end else begin
					feed_next = pending.pop_front();
					valid <= 1'b1;
					value <= feed_next.value;
					last <= feed_next.last;
				end
			end
		end
	end

	// receiver: checks each result transfer and stalls in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (sorted_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result value %0d final %b truncated %b",
						$time, value_res, final_item, truncated);
				end else begin
					due_head = sorted_due.pop_front();
					if (value_res !== due_head.value) begin
						errors++;
						$display("%0t: value_res expected %0d actual %0d",
							$time, due_head.value, value_res);
					end
					if (final_item !== due_head.final_item) begin
						errors++;
						$display("%0t: final_item expected %b actual %b",
							$time, due_head.final_item, final_item);
					end
					if (truncated !== due_head.truncated) begin
						errors++;
						$display("%0t: truncated expected %b actual %b",
							$time, due_head.truncated, truncated);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if (pending.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 5);
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int n;
		int r;
		int sets;
		errors = 0;
		items_queued = 0;
		cycle_count = 0;
		set_dropped = 1'b0;

		// directed: single extremes, edge mix, duplicates, reversed, sorted and a two-element set
		queue_item(32'sh7FFF_FFFF, 1'b1, 1'b0);
		queue_item(32'sh8000_0000, 1'b1, 1'b1);
		queue_item(0, 1'b0, 1'b0);
		queue_item(-1, 1'b0, 1'b0);
		queue_item(1, 1'b0, 1'b0);
		queue_item(32'sh7FFF_FFFF, 1'b0, 1'b0);
		queue_item(32'sh8000_0000, 1'b0, 1'b0);
		queue_item(32'sh7FFF_FFFF, 1'b0, 1'b0);
		queue_item(32'sh8000_0000, 1'b0, 1'b0);
		queue_item(-1, 1'b0, 1'b0);
		queue_item(0, 1'b1, 1'b0);
		queue_item(5, 1'b0, 1'b0);
		queue_item(5, 1'b0, 1'b0);
		queue_item(5, 1'b1, 1'b0);
		queue_set(4, MIX_FALLING, 1'b0);
		queue_set(3, MIX_RISING, 1'b0);
		queue_item(32'sh5555_5555, 1'b0, 1'b0);
		queue_item(32'shAAAA_AAAA, 1'b1, 1'b0);

		// random: exactly full and one-over sets first, then mostly small sets
		items_queued = 0;
		queue_set(STORE_DEPTH, MIX_WIDE, 1'b1);
		queue_set(STORE_DEPTH + 1, MIX_DUPS, 1'b0);
		sets = 0;
		while (items_queued < RANDOM_ITEMS) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				n = $urandom_range(STORE_DEPTH - 1, STORE_DEPTH + 8);
			else if (r < 4)
				n = $urandom_range(17, 40);
			else
				n = $urandom_range(1, 16);
			queue_set(n, val_mix_t'($urandom_range(0, 4)), sets % 12 == 11);
			sets++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || valid)
			@(posedge clk);
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
